>>> rtl/core/bmr_pkg.sv
package bmr_pkg;

  // Store geometry and fixed-point format.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int FRAC_BITS  = 8;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CW    = (XW > YW) ? XW : YW;
  localparam int DIM_W = 7;
  localparam int PIX_W = 16;

  // Coordinate divider: numerator t*(s-1)*2^F, quotient holds integer and fraction.
  localparam int NUM_W = 2 * CW + FRAC_BITS;
  localparam int QUO_W = CW + FRAC_BITS;

  // Four banks split by the parity of column and row.
  localparam int BANK_AW    = (XW - 1) + (YW - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Blend arithmetic widths.
  localparam int WGT_W = FRAC_BITS + 1;
  localparam int ROW_W = PIX_W + WGT_W;
  localparam int SUM_W = ROW_W + WGT_W;

  // Edges from the start beat to the edge that samples the result strobe.
  localparam int LATENCY = QUO_W + 7;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_REQ   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_TGT_W  = 3'd2,
    REG_TGT_H  = 3'd3,
    REG_MODE   = 3'd4
  } reg_idx_t;

  localparam logic [1:0] MODE_STRICT = 2'd0;

  // Per-beat side information that travels with the coordinate pipeline.
  typedef struct packed {
    cmd_t              cmd;
    logic [PIX_W-1:0]  pin;
    status_t           status;
    logic              zero;
  } tag_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [CW-1:0]    den;
    logic [QUO_W-1:0] quo;
  } lane_t;

  // Access to the banked source store: one write or a 2x2 neighborhood read.
  typedef struct packed {
    logic             valid;
    logic             we;
    logic [XW-1:0]    x0;
    logic [XW-1:0]    x1;
    logic [YW-1:0]    y0;
    logic [YW-1:0]    y1;
    logic [PIX_W-1:0] wdata;
  } mem_req_t;

  // A dimension register of 0 acts as 1, any value above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bmr_coord_div.sv
module bmr_coord_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  bmr_pkg::tag_t              in_tag,
  input  logic [bmr_pkg::CW-1:0]     t_x,
  input  logic [bmr_pkg::CW-1:0]     m_x,
  input  logic [bmr_pkg::CW-1:0]     d_x,
  input  logic [bmr_pkg::CW-1:0]     t_y,
  input  logic [bmr_pkg::CW-1:0]     m_y,
  input  logic [bmr_pkg::CW-1:0]     d_y,
  output logic                       out_valid,
  output bmr_pkg::tag_t              out_tag,
  output logic [bmr_pkg::QUO_W-1:0]  q_x,
  output logic [bmr_pkg::QUO_W-1:0]  q_y
);
  import bmr_pkg::*;

  // Stage 0 forms the numerators, stages 1..QUO_W resolve one quotient bit each.
  logic [QUO_W:0] v_r;
  tag_t           tag_r [QUO_W+1];
  lane_t          lx_r  [QUO_W+1];
  lane_t          ly_r  [QUO_W+1];

  function automatic lane_t div_step(input lane_t l, input int i);
    lane_t            o;
    logic [NUM_W-1:0] trial;
    o     = l;
    trial = NUM_W'(l.den) << i;
    if (l.rem >= trial) begin
      o.rem    = l.rem - trial;
      o.quo[i] = 1'b1;
    end
    return o;
  endfunction

  function automatic lane_t load(input logic [CW-1:0] t, input logic [CW-1:0] m,
                                 input logic [CW-1:0] d);
    lane_t           o;
    logic [2*CW-1:0] prod;
    prod  = {{CW{1'b0}}, t} * {{CW{1'b0}}, m};
    o.rem = {prod, {FRAC_BITS{1'b0}}};
    o.den = d;
    o.quo = '0;
    return o;
  endfunction

  // Valid bits shift along with the beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QUO_W-1:0], in_valid};
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    lx_r[0]  <= load(t_x, m_x, d_x);
    ly_r[0]  <= load(t_y, m_y, d_y);
    for (int k = 1; k <= QUO_W; k++) begin
      tag_r[k] <= tag_r[k-1];
      lx_r[k]  <= div_step(lx_r[k-1], QUO_W - k);
      ly_r[k]  <= div_step(ly_r[k-1], QUO_W - k);
    end
  end

  assign out_valid = v_r[QUO_W];
  assign out_tag   = tag_r[QUO_W];
  assign q_x       = lx_r[QUO_W].quo;
  assign q_y       = ly_r[QUO_W].quo;

endmodule

>>> rtl/core/bmr_store.sv
module bmr_store (
  input  logic                                clk,
  input  bmr_pkg::mem_req_t                   req,
  output logic [3:0][bmr_pkg::PIX_W-1:0]      rd_data
);
  import bmr_pkg::*;

  // Bank {row parity, column parity}; a 2x2 neighborhood hits each bank once.
  for (genvar gy = 0; gy < 2; gy++) begin : g_row
    for (genvar gx = 0; gx < 2; gx++) begin : g_col
      logic [PIX_W-1:0]   mem [BANK_DEPTH];
      logic [XW-1:0]      xs;
      logic [YW-1:0]      ys;
      logic [BANK_AW-1:0] addr;
      logic               hit_w;

      // A read picks whichever neighbor column and row has this bank's parity.
      assign xs    = (req.x0[0] == 1'(gx)) ? req.x0 : req.x1;
      assign ys    = (req.y0[0] == 1'(gy)) ? req.y0 : req.y1;
      assign addr  = {ys[YW-1:1], xs[XW-1:1]};
      assign hit_w = req.valid && req.we && (req.x0[0] == 1'(gx)) && (req.y0[0] == 1'(gy));

      // Single port: one write or one read per cycle, read data registered.
      always_ff @(posedge clk) begin
        if (hit_w) begin
          mem[addr] <= req.wdata;
        end else if (req.valid && !req.we) begin
          rd_data[gy*2+gx] <= mem[addr];
        end
      end
    end
  end

endmodule

>>> rtl/core/bmr_blend.sv
module bmr_blend (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  bmr_pkg::status_t                   in_status,
  input  logic                               in_zero,
  input  logic [3:0][bmr_pkg::PIX_W-1:0]     rd_data,
  input  logic                               x0p,
  input  logic                               x1p,
  input  logic                               y0p,
  input  logic                               y1p,
  input  logic [bmr_pkg::FRAC_BITS-1:0]      fx,
  input  logic [bmr_pkg::FRAC_BITS-1:0]      fy,
  output logic                               out_valid,
  output logic [bmr_pkg::PIX_W-1:0]          out_pixel,
  output bmr_pkg::status_t                   out_status
);
  import bmr_pkg::*;

  localparam logic [WGT_W-1:0] ONE  = WGT_W'(1) << FRAC_BITS;
  localparam logic [PIX_W-1:0] BIAS = PIX_W'(1) << (PIX_W - 1);
  localparam int               UW   = SUM_W - 2 * FRAC_BITS;

  logic [PIX_W-1:0] a00, a10, a01, a11;
  logic [WGT_W-1:0] wfx, wfy;
  logic [ROW_W-1:0] l1_r, l2_r;
  logic [WGT_W-1:0] wfy_r;
  logic [SUM_W-1:0] sum_r;
  logic [1:0]       v_r;
  status_t          st1_r, st2_r;
  logic             z1_r, z2_r;
  logic [UW-1:0]    u;
  logic [PIX_W-1:0] pix;

  // Neighbors in offset binary so that the weights stay unsigned.
  assign a00 = rd_data[{y0p, x0p}] ^ BIAS;
  assign a10 = rd_data[{y0p, x1p}] ^ BIAS;
  assign a01 = rd_data[{y1p, x0p}] ^ BIAS;
  assign a11 = rd_data[{y1p, x1p}] ^ BIAS;
  assign wfx = WGT_W'(fx);
  assign wfy = WGT_W'(fy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[0], in_valid};
    end
  end

  // Horizontal blend of both rows, then vertical blend.
  always_ff @(posedge clk) begin
    l1_r  <= ROW_W'(a00) * (ONE - wfx) + ROW_W'(a10) * wfx;
    l2_r  <= ROW_W'(a01) * (ONE - wfx) + ROW_W'(a11) * wfx;
    wfy_r <= wfy;
    st1_r <= in_status;
    z1_r  <= in_zero;
    sum_r <= SUM_W'(l1_r) * (ONE - wfy_r) + SUM_W'(l2_r) * wfy_r;
    st2_r <= st1_r;
    z2_r  <= z1_r;
  end

  // Round half up, saturate, and return to two's complement; a zero beat or an error status gives zero.
  always_comb begin
    u   = UW'((sum_r + (SUM_W'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS));
    pix = (u > UW'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : u[PIX_W-1:0];
    if (z2_r || st2_r != ST_OK) begin
      pix = '0;
    end else begin
      pix = pix ^ BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_r[1];
    end
    out_pixel  <= pix;
    out_status <= st2_r;
  end

endmodule

>>> rtl/core/bilinear_map_resize.sv
// A request's result strobe follows its start beat through the input register, the 15-stage
// coordinate divider, the address stage, the store read and 3 blend stages.
// Throughput: one beat per clock, writes and requests mixed; busy stays low.
// All store accesses happen in order at one pipeline stage, so writes and reads never pass.
// Reset loads default settings and clears the pipeline; the store keeps its contents.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bilinear_map_resize (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_cmd,
  input  logic [bmr_pkg::XW-1:0]               in_pos_x,
  input  logic [bmr_pkg::YW-1:0]               in_pos_y,
  input  logic signed [bmr_pkg::PIX_W-1:0]     in_pixel_in,
  input  logic                                 cfg_we,
  input  logic [2:0]                           cfg_index,
  input  logic [bmr_pkg::DIM_W-1:0]            cfg_data,
  output logic                                 out_valid,
  output logic signed [bmr_pkg::PIX_W-1:0]     out_pixel_out,
  output logic [1:0]                           out_status
);
  import bmr_pkg::*;

  logic [DIM_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic [1:0]       mode_r;
  logic [DIM_W-1:0] sw, sh, tw, th, px_d, py_d;
  logic             same, scale, refused, outside, inside_src, accept;
  tag_t             tag_in;
  logic [CW-1:0]    mx, dx, my, dy;

  logic             v0_r;
  tag_t             tag0_r;
  logic [CW-1:0]    px0_r, py0_r, mx_r, dx_r, my_r, dy_r;

  logic             dv;
  tag_t             dtag;
  logic [QUO_W-1:0] dq_x, dq_y;
  logic [XW-1:0]    x0, x1;
  logic [YW-1:0]    y0, y1;
  logic [FRAC_BITS-1:0] fx, fy;

  mem_req_t         req_r;
  tag_t             taga_r;
  logic [FRAC_BITS-1:0] fxa_r, fya_r;

  logic             vm_r;
  tag_t             tagm_r;
  logic [FRAC_BITS-1:0] fxm_r, fym_r;
  logic             x0p_r, x1p_r, y0p_r, y1p_r;
  logic [3:0][PIX_W-1:0] rd_data;
  status_t          bl_status;
  logic [PIX_W-1:0] bl_pixel;

  // Every cycle takes a beat.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_W'(MAX_WIDTH);
      src_h_r <= DIM_W'(MAX_HEIGHT);
      tgt_w_r <= DIM_W'(MAX_WIDTH);
      tgt_h_r <= DIM_W'(MAX_HEIGHT);
      mode_r  <= MODE_STRICT;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SRC_W: src_w_r <= cfg_data;
        REG_SRC_H: src_h_r <= cfg_data;
        REG_TGT_W: tgt_w_r <= cfg_data;
        REG_TGT_H: tgt_h_r <= cfg_data;
        REG_MODE:  mode_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Decode the beat: status, copy or zero, and the divider operands per axis.
  assign sw         = clamp_dim(src_w_r, MAX_WIDTH);
  assign sh         = clamp_dim(src_h_r, MAX_HEIGHT);
  assign tw         = clamp_dim(tgt_w_r, MAX_WIDTH);
  assign th         = clamp_dim(tgt_h_r, MAX_HEIGHT);
  assign px_d       = DIM_W'(in_pos_x);
  assign py_d       = DIM_W'(in_pos_y);
  assign same       = (sw == tw) && (sh == th);
  assign scale      = mode_r[1];
  assign refused    = !same && (mode_r == MODE_STRICT) && ((tw < sw) || (th < sh));
  assign outside    = (px_d >= tw) || (py_d >= th);
  assign inside_src = (px_d < sw) && (py_d < sh);

  always_comb begin
    tag_in.cmd    = cmd_t'(in_cmd);
    tag_in.pin    = in_pixel_in;
    tag_in.status = refused ? ST_REFUSED : (outside ? ST_OUTSIDE : ST_OK);
    tag_in.zero   = !same && !scale && !inside_src;
    // Copy and writes divide by one, so the coordinate is the position itself.
    mx = CW'(1);
    dx = CW'(1);
    my = CW'(1);
    dy = CW'(1);
    if (cmd_t'(in_cmd) == CMD_REQ && scale && !same) begin
      if (tw > DIM_W'(1)) begin
        mx = CW'(sw - DIM_W'(1));
        dx = CW'(tw - DIM_W'(1));
      end else begin
        mx = '0;
      end
      if (th > DIM_W'(1)) begin
        my = CW'(sh - DIM_W'(1));
        dy = CW'(th - DIM_W'(1));
      end else begin
        my = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    tag0_r <= tag_in;
    px0_r  <= CW'(in_pos_x);
    py0_r  <= CW'(in_pos_y);
    mx_r   <= mx;
    dx_r   <= dx;
    my_r   <= my;
    dy_r   <= dy;
  end

  bmr_coord_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_tag    (tag0_r),
    .t_x       (px0_r),
    .m_x       (mx_r),
    .d_x       (dx_r),
    .t_y       (py0_r),
    .m_y       (my_r),
    .d_y       (dy_r),
    .out_valid (dv),
    .out_tag   (dtag),
    .q_x       (dq_x),
    .q_y       (dq_y)
  );

  // Neighbor coordinates; the far neighbor is held inside the source.
  always_comb begin
    x0 = XW'(dq_x[QUO_W-1:FRAC_BITS]);
    y0 = YW'(dq_y[QUO_W-1:FRAC_BITS]);
    fx = dq_x[FRAC_BITS-1:0];
    fy = dq_y[FRAC_BITS-1:0];
    x1 = ((fx != '0) && (DIM_W'(x0) < sw - DIM_W'(1))) ? x0 + XW'(1) : x0;
    y1 = ((fy != '0) && (DIM_W'(y0) < sh - DIM_W'(1))) ? y0 + YW'(1) : y0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
    end else begin
      req_r.valid <= dv;
      req_r.we    <= (dtag.cmd == CMD_WRITE);
      req_r.x0    <= x0;
      req_r.x1    <= x1;
      req_r.y0    <= y0;
      req_r.y1    <= y1;
      req_r.wdata <= dtag.pin;
    end
    taga_r <= dtag;
    fxa_r  <= fx;
    fya_r  <= fy;
  end

  bmr_store u_store (
    .clk     (clk),
    .req     (req_r),
    .rd_data (rd_data)
  );

  // Side data aligned with the registered read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= req_r.valid && !req_r.we;
    end
    tagm_r <= taga_r;
    fxm_r  <= fxa_r;
    fym_r  <= fya_r;
    x0p_r  <= req_r.x0[0];
    x1p_r  <= req_r.x1[0];
    y0p_r  <= req_r.y0[0];
    y1p_r  <= req_r.y1[0];
  end

  bmr_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vm_r),
    .in_status  (tagm_r.status),
    .in_zero    (tagm_r.zero),
    .rd_data    (rd_data),
    .x0p        (x0p_r),
    .x1p        (x1p_r),
    .y0p        (y0p_r),
    .y1p        (y1p_r),
    .fx         (fxm_r),
    .fy         (fym_r),
    .out_valid  (out_valid),
    .out_pixel  (bl_pixel),
    .out_status (bl_status)
  );

  assign out_pixel_out = bl_pixel;
  assign out_status    = bl_status;

endmodule

>>> rtl/core/bmr_checker.sv
module bmr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              in_cmd,
  input logic                              out_valid,
  input logic signed [bmr_pkg::PIX_W-1:0]  out_pixel_out,
  input logic [1:0]                        out_status
);
  import bmr_pkg::*;

  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             req;
  logic             warm;

  // Edges since reset, saturating once a full pipeline depth has gone by.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cnt_r != CNT_W'(LATENCY)) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign req  = start && !busy && (cmd_t'(in_cmd) == CMD_REQ);
  assign warm = (cnt_r == CNT_W'(LATENCY));

  // A result beat appears only for a request taken one pipeline depth earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (warm && $past(req, LATENCY)))
    else $error("result beat without a matching request");

  // Every request taken yields its result beat after the pipeline depth.
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && $past(req, LATENCY)) |-> out_valid)
    else $error("request lost in the pipeline");

  // A refused or outside pixel reads as zero.
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_pixel_out == '0))
    else $error("nonzero pixel with error status");

endmodule

bind bilinear_map_resize bmr_checker u_bmr_checker (.*);
